// ----- rtl/core/shp_pkg.sv -----
// Shared types and constants of the 3x3 sharpening filter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package shp_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 12;
    localparam int CMP_W     = DIM_W + 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int OROW_W    = $clog2(MAX_HEIGHT);
    localparam int IROW_W    = OROW_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int TAPS      = 9;
    localparam int NSUM_W    = PIX_W + 3;
    localparam int PSUM_W    = PIX_W + 4;

    localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(1024);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic produce;
        logic last;
        logic m_top;
        logic m_bot;
        logic m_left;
        logic m_right;
    } t_tag;

    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/shp_pos_ctrl.sv -----
// Frame size registers and input/output position counters of the filter.
// Produces the per-transaction tag with border masks. Depends on shp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shp_pos_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [shp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [shp_pkg::DIM_W-1:0]      i_cfg_data,
    output logic                           o_cfg_ready,
    input  logic                           i_acc,
    input  logic [shp_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_flush,
    output logic [shp_pkg::COL_W-1:0]      o_col,
    output logic [shp_pkg::PIX_W-1:0]      o_pix,
    output shp_pkg::t_tag                  o_tag
);
    import shp_pkg::*;

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [COL_W-1:0]  r_in_col;
    logic [IROW_W-1:0] r_in_row;
    logic [COL_W-1:0]  r_out_col;
    logic [OROW_W-1:0] r_out_row;

    logic cfg_wr;
    logic in_col_end;
    logic row_done;
    logic first_line;
    logic out_col_end;
    logic out_row_end;
    logic last;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        in_col_end  = (DIM_W'(r_in_col) + DIM_W'(1)) == r_width;
        row_done    = CMP_W'(r_in_row) >= CMP_W'(r_height);
        first_line  = (r_in_row == '0) || ((r_in_row == IROW_W'(1)) && (r_in_col == '0));
        out_col_end = (DIM_W'(r_out_col) + DIM_W'(1)) == r_width;
        out_row_end = (CMP_W'(r_out_row) + CMP_W'(1)) == CMP_W'(r_height);
        last        = !first_line && out_col_end && out_row_end;

        o_col         = r_in_col;
        o_pix         = (i_flush || row_done) ? '0 : i_pixel;
        o_tag.produce = !first_line;
        o_tag.last    = last;
        o_tag.m_top   = r_out_row != '0;
        o_tag.m_bot   = !out_row_end;
        o_tag.m_left  = r_out_col != '0;
        o_tag.m_right = !out_col_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RESET_DIM;
            r_height  <= RESET_DIM;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                r_width <= dim_eff(i_cfg_data, DIM_W'(MAX_WIDTH));
            end
            if (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end
            if (i_cfg_index == REG_FRAME_HEIGHT) begin
                r_height <= dim_eff(i_cfg_data, DIM_W'(MAX_HEIGHT));
            end
        end else if (i_acc) begin
            if (last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (in_col_end) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + IROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
                if (!first_line) begin
                    if (out_col_end) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + OROW_W'(1);
                    end else begin
                        r_out_col <= r_out_col + COL_W'(1);
                    end
                end
            end
        end
    end

    // The input column always lies inside the configured line.
    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(r_in_col) < r_width)
        else $error("input column outside the line");

    // The output row always lies inside the configured frame.
    a_out_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_out_row) < CMP_W'(r_height))
        else $error("output row outside the frame");

endmodule

`default_nettype wire

// ----- rtl/core/shp_line_buf.sv -----
// Line store of the filter: one memory holding the two previous lines per column.
// Reads on acceptance, writes back on advance, with forwarding. Depends on shp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shp_line_buf (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  logic [shp_pkg::COL_W-1:0]  i_col,
    input  logic [shp_pkg::PIX_W-1:0]  i_pix,
    input  logic                       i_adv,
    output logic [shp_pkg::PIX_W-1:0]  o_up,
    output logic [shp_pkg::PIX_W-1:0]  o_lo,
    output logic [shp_pkg::PIX_W-1:0]  o_pix
);
    import shp_pkg::*;

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic [COL_W-1:0]   r_col;
    logic [PIX_W-1:0]   r_pix;
    logic               r_pend;
    logic               r_fwd;
    logic [PIX_W-1:0]   r_fwd_up;
    logic [PIX_W-1:0]   r_fwd_lo;

    always_comb begin
        o_up  = r_fwd ? r_fwd_up : r_rd[2*PIX_W-1:PIX_W];
        o_lo  = r_fwd ? r_fwd_lo : r_rd[PIX_W-1:0];
        o_pix = r_pix;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            mem[r_col] <= {o_lo, r_pix};
        end
        if (i_acc) begin
            r_rd <= mem[i_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_col    <= i_col;
            r_pix    <= i_pix;
            r_fwd_up <= o_lo;
            r_fwd_lo <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            if (i_acc) begin
                r_pend <= 1'b1;
                r_fwd  <= r_pend && (r_col == i_col);
            end else if (i_adv) begin
                r_pend <= 1'b0;
            end
        end
    end

    // A new read may only overtake a pending write when that write lands in the same cycle.
    a_pend_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_pend) |-> i_adv)
        else $error("read issued over an unwritten line store entry");

endmodule

`default_nettype wire

// ----- rtl/core/shp_kernel.sv -----
// 3x3 window, border masking, sharpening arithmetic and output register.
// Depends on shp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shp_kernel (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic [shp_pkg::PIX_W-1:0]  i_up,
    input  logic [shp_pkg::PIX_W-1:0]  i_lo,
    input  logic [shp_pkg::PIX_W-1:0]  i_pix,
    input  shp_pkg::t_tag              i_tag,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic [shp_pkg::PIX_W-1:0]  o_pixel,
    output logic                       o_last,
    input  logic                       i_stall
);
    import shp_pkg::*;

    logic [PIX_W-1:0]  r_win [TAPS];
    logic              r_s2_valid;
    t_tag              r_s2_tag;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_last;

    logic              s2_move;
    logic [NSUM_W-1:0] neg;
    logic [PSUM_W-1:0] pos;
    logic [PSUM_W-1:0] diff;
    logic [PIX_W-1:0]  res;

    assign s2_move = r_s2_valid && (!r_out_valid || !i_stall);
    assign o_ready = !r_s2_valid || s2_move;
    assign o_valid = r_out_valid;
    assign o_pixel = r_out_pix;
    assign o_last  = r_out_last;

    always_comb begin
        logic row_ok;
        logic col_ok;
        neg = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                row_ok = (r == 0) ? r_s2_tag.m_top : ((r == 2) ? r_s2_tag.m_bot : 1'b1);
                col_ok = (c == 0) ? r_s2_tag.m_left : ((c == 2) ? r_s2_tag.m_right : 1'b1);
                if (!(r == 1 && c == 1) && row_ok && col_ok) begin
                    neg = neg + NSUM_W'(r_win[r*3+c]);
                end
            end
        end
        pos  = {r_win[4], 4'b0000};
        diff = pos - PSUM_W'(neg);
        if (PSUM_W'(neg) > pos) begin
            res = '0;
        end else if (diff[PSUM_W-1]) begin
            res = '1;
        end else begin
            res = diff[PSUM_W-2:3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= i_up;
            r_win[5] <= i_lo;
            r_win[8] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_s2_tag <= i_tag;
        end
        if (s2_move) begin
            r_out_pix  <= res;
            r_out_last <= r_s2_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_shift) begin
                r_s2_valid <= i_tag.produce;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // The window may only move while the compute stage is free or draining.
    a_window_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_shift |-> (!r_s2_valid || s2_move))
        else $error("window shifted under a held result");

endmodule

`default_nettype wire

// ----- rtl/core/sharpen_3x3_zero_border.sv -----
// Top level of the streaming 3x3 sharpening filter with zero border.
// Instantiates shp_pos_ctrl, shp_line_buf and shp_kernel; depends on shp_pkg.
//
// Usage: pixels of one frame enter in raster order on the input channel
// (i_valid, o_stall, i_pixel_in, i_is_flush). After the last pixel of a frame
// the source sends frame_width + 1 flush transactions to drain the last lines.
// Each result is 16 times the centre minus its in-frame neighbors, divided by
// eight and clamped to 0..255; o_last_of_frame marks the final pixel.
// The frame size is written through i_cfg_valid, i_cfg_index and i_cfg_data
// while the block is idle; o_cfg_ready is always high, and any write of a
// defined register restarts the frame.
// Throughput is one transaction per cycle while o_stall is low. The output for
// a pixel is caused by the transaction one line plus one pixel later; that
// transaction passes the line store read stage, then the window arithmetic
// stage and then the output register before it reaches the output channel.
// Reset restores both sizes to 1024 and clears all positions; the line store
// is not cleared. When the receiver stalls, the output register and the
// compute stage hold, and o_stall rises once the read stage is also full.
`timescale 1ns / 1ps
`default_nettype none

module sharpen_3x3_zero_border (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [shp_pkg::PIX_W-1:0]      i_pixel_in,
    input  logic                           i_is_flush,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [shp_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                           o_last_of_frame,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [shp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [shp_pkg::DIM_W-1:0]      i_cfg_data
);
    import shp_pkg::*;

    logic             acc;
    logic             s1_adv;
    logic             k_ready;
    logic             r_s1_valid;
    t_tag             r_s1_tag;
    logic [COL_W-1:0] pc_col;
    logic [PIX_W-1:0] pc_pix;
    t_tag             pc_tag;
    logic [PIX_W-1:0] lb_up;
    logic [PIX_W-1:0] lb_lo;
    logic [PIX_W-1:0] lb_pix;

    assign o_stall = r_s1_valid && !k_ready;
    assign acc     = i_valid && !o_stall;
    assign s1_adv  = r_s1_valid && k_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_tag <= pc_tag;
        end
    end

    shp_pos_ctrl u_pos_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_acc       (acc),
        .i_pixel     (i_pixel_in),
        .i_flush     (i_is_flush),
        .o_col       (pc_col),
        .o_pix       (pc_pix),
        .o_tag       (pc_tag)
    );

    shp_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_col   (pc_col),
        .i_pix   (pc_pix),
        .i_adv   (s1_adv),
        .o_up    (lb_up),
        .o_lo    (lb_lo),
        .o_pix   (lb_pix)
    );

    shp_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_adv),
        .i_up    (lb_up),
        .i_lo    (lb_lo),
        .i_pix   (lb_pix),
        .i_tag   (r_s1_tag),
        .o_ready (k_ready),
        .o_valid (o_valid),
        .o_pixel (o_pixel_out),
        .o_last  (o_last_of_frame),
        .i_stall (i_stall)
    );

endmodule

`default_nettype wire
